// ----- rtl/rld_pkg.sv -----
// Shared types and constants for the run-length RGB565 line decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rld_pkg;

  // Default limits on the usable image size.
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Result kinds.
  localparam logic [1:0] KIND_CTRL    = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [15:0] code_word;
    logic        restart;
  } rld_in_t;

  // Decoded pixel beat, before the frame address is formed.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        line_end;
    logic        image_end;
  } rld_pix_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [25:0] byte_address;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        line_end;
    logic        image_end;
  } rld_out_t;

endpackage

`default_nettype wire

// ----- rtl/rld_decode.sv -----
// Line-code parser: holds the decoder state and the first pipeline register.
// Depends on rld_pkg for the beat types and result kinds.
`default_nettype none

module rld_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire rld_pkg::rld_in_t  item,
  input  wire logic [11:0]       eff_w,
  input  wire logic [11:0]       eff_h,
  output rld_pkg::rld_pix_t      pix_r
);
  import rld_pkg::*;

  typedef enum logic [2:0] {
    PH_CODE,
    PH_FULL,
    PH_BLANK,
    PH_COUNT,
    PH_RUN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [11:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] pairs_r, pairs_nxt;
  logic [15:0] pix_left_r, pix_left_nxt;
  rld_pix_t    pix_nxt;

  logic        emit;
  logic        pair_done;
  logic        line_done;
  logic [16:0] blank_sum;
  logic [15:0] word;

  assign word = item.code_word;

  // Next state and decoded beat for the word on the input.
  always_comb begin
    phase_nxt    = phase_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    pairs_nxt    = pairs_r;
    pix_left_nxt = pix_left_r;
    pix_nxt      = '0;
    emit         = 1'b0;
    pair_done    = 1'b0;
    line_done    = 1'b0;
    blank_sum    = '0;

    // A restart clears the decoder before this word is taken as a line code.
    if (item.restart) begin
      phase_nxt    = PH_CODE;
      line_nxt     = '0;
      col_nxt      = '0;
      pairs_nxt    = '0;
      pix_left_nxt = '0;
    end

    case (phase_nxt)
      PH_CODE: begin
        if (line_nxt >= eff_h) begin
          pix_nxt.kind = KIND_IGNORED;
        end else begin
          col_nxt = '0;
          if (word == 16'd0) begin
            line_done = 1'b1;
          end else if (word == 16'd1) begin
            pix_left_nxt = {4'b0, eff_w};
            if (eff_w == 12'd0) begin
              line_done = 1'b1;
            end else begin
              phase_nxt = PH_FULL;
            end
          end else begin
            pairs_nxt = word - 16'd1;
            phase_nxt = PH_BLANK;
          end
        end
      end
      PH_FULL: begin
        emit         = 1'b1;
        pix_left_nxt = pix_left_nxt - 16'd1;
        line_done    = (pix_left_nxt == 16'd0);
      end
      PH_BLANK: begin
        blank_sum = {1'b0, col_nxt} + {1'b0, word};
        col_nxt   = blank_sum[16] ? 16'hFFFF : blank_sum[15:0];
        phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        pix_left_nxt = word;
        if (word == 16'd0) begin
          pair_done = 1'b1;
        end else begin
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN: begin
        emit         = 1'b1;
        pix_left_nxt = pix_left_nxt - 16'd1;
        pair_done    = (pix_left_nxt == 16'd0);
      end
      default: begin
        phase_nxt    = PH_CODE;
        line_nxt     = '0;
        col_nxt      = '0;
        pairs_nxt    = '0;
        pix_left_nxt = '0;
        pix_nxt.kind = KIND_IGNORED;
      end
    endcase

    // Pixel word: written when inside the line, otherwise dropped.
    if (emit) begin
      pix_nxt.row = eff_h - 12'd1 - line_nxt;
      if (col_nxt < {4'b0, eff_w}) begin
        pix_nxt.kind   = KIND_PIXEL;
        pix_nxt.column = col_nxt[11:0];
        pix_nxt.red    = {word[15:11], 3'b000};
        pix_nxt.green  = {word[10:5], 2'b00};
        pix_nxt.blue   = {word[4:0], 3'b000};
      end else begin
        pix_nxt.kind   = KIND_DROP;
        pix_nxt.column = (|col_nxt[15:12]) ? 12'hFFF : col_nxt[11:0];
      end
      if (col_nxt != 16'hFFFF) begin
        col_nxt = col_nxt + 16'd1;
      end
    end

    // End of a blank/pixel pair.
    if (pair_done) begin
      pairs_nxt = pairs_nxt - 16'd1;
      if (pairs_nxt == 16'd0) begin
        line_done = 1'b1;
      end else begin
        phase_nxt = PH_BLANK;
      end
    end

    // End of a line.
    if (line_done) begin
      pix_nxt.line_end  = 1'b1;
      pix_nxt.image_end = (({1'b0, line_nxt} + 13'd1) >= {1'b0, eff_h});
      if (line_nxt != 12'hFFF) begin
        line_nxt = line_nxt + 12'd1;
      end
      col_nxt      = '0;
      pairs_nxt    = '0;
      pix_left_nxt = '0;
      phase_nxt    = PH_CODE;
    end
  end

  // Decoder state and the decoded beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CODE;
      line_r     <= '0;
      col_r      <= '0;
      pairs_r    <= '0;
      pix_left_r <= '0;
    end else if (load) begin
      phase_r    <= phase_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      pairs_r    <= pairs_nxt;
      pix_left_r <= pix_left_nxt;
      pix_r      <= pix_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rld_addr.sv -----
// Frame address stage: forms the padded bottom-up byte address and holds
// the result register. Depends on rld_pkg for the beat types.
`default_nettype none

module rld_addr (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire rld_pkg::rld_pix_t pix,
  input  wire logic [11:0]       eff_w,
  output rld_pkg::rld_out_t      out_r
);
  import rld_pkg::*;

  logic [13:0] stride_raw;
  logic [13:0] stride;
  logic [25:0] row_base;
  logic [13:0] col_off;
  logic [26:0] addr_sum;
  rld_out_t    out_nxt;

  // Row stride is three bytes per pixel rounded up to a multiple of four.
  assign stride_raw = {2'b00, eff_w} + {1'b0, eff_w, 1'b0} + 14'd3;
  assign stride     = {stride_raw[13:2], 2'b00};
  assign row_base   = {14'b0, pix.row} * {12'b0, stride};
  assign col_off    = {2'b00, pix.column} + {1'b0, pix.column, 1'b0};
  assign addr_sum   = {1'b0, row_base} + {13'b0, col_off};

  always_comb begin
    out_nxt.kind         = pix.kind;
    out_nxt.byte_address = (pix.kind == KIND_PIXEL) ? addr_sum[25:0] : 26'd0;
    out_nxt.row          = pix.row;
    out_nxt.column       = pix.column;
    out_nxt.red          = pix.red;
    out_nxt.green        = pix.green;
    out_nxt.blue         = pix.blue;
    out_nxt.line_end     = pix.line_end;
    out_nxt.image_end    = pix.image_end;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/run_length_rgb565_line_decoder.sv -----
// Run-length RGB565 line decoder, top level. Uses rld_pkg, rld_decode, rld_addr.
//
// The input channel (in_valid/in_ready/in_data) takes one 16-bit stream word
// per beat: a line code, a blank count, a pixel count or an RGB565 pixel,
// with a restart flag that returns the decoder to the first line. For every
// input beat exactly one result beat leaves on out_valid/out_ready/out_data:
// a control word, a pixel write with row, column and byte address, a dropped
// pixel past the line width, or a word ignored after the image end.
// Throughput is one word per cycle while the receiver does not stall. The
// accepting edge loads the line-code parser register; the address multiply
// is then loaded into the result register, from which the result leaves.
// If the receiver stalls, the result and the parsed word behind it hold
// their registers and in_ready drops once both are full. The width and
// height registers sit on an APB-style port at byte addresses 0 and 4; they
// reset to 1. Reset also returns the decoder to the first line expecting a
// line code and empties the pipeline.
`default_nettype none

module run_length_rgb565_line_decoder #(
  parameter int MAX_WIDTH  = rld_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rld_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rld_pkg::rld_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rld_pkg::rld_out_t     out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import rld_pkg::*;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [11:0] width_r;
  logic [11:0] height_r;
  logic [11:0] eff_w;
  logic [11:0] eff_h;
  logic        cfg_write;

  logic        s1_v_r, s1_v_nxt;
  logic        s2_v_r, s2_v_nxt;
  logic        in_fire;
  logic        s2_load;
  rld_pix_t    pix;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd1;
      height_r <= 12'd1;
    end else if (cfg_write) begin
      if (paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[11:0];
      end else begin
        height_r <= pwdata[11:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {20'b0, height_r} : {20'b0, width_r};

  // Usable size, limited below the configured maximum.
  assign eff_w = (32'(width_r) >= 32'(MAX_WIDTH)) ? 12'(MAX_WIDTH - 1) : width_r;
  assign eff_h = (32'(height_r) >= 32'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT - 1) : height_r;

  // Two-stage pipeline flow control.
  assign s2_load  = s1_v_r && (!s2_v_r || out_ready);
  assign in_ready = !s1_v_r || s2_load;
  assign in_fire  = in_valid && in_ready;

  assign s1_v_nxt = in_fire ? 1'b1 : (s2_load ? 1'b0 : s1_v_r);
  assign s2_v_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : s2_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  assign out_valid = s2_v_r;

  rld_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_fire),
    .item  (in_data),
    .eff_w (eff_w),
    .eff_h (eff_h),
    .pix_r (pix)
  );

  rld_addr u_addr (
    .clk   (clk),
    .load  (s2_load),
    .pix   (pix),
    .eff_w (eff_w),
    .out_r (out_data)
  );

`ifndef SYNTHESIS
  // A written pixel always lies inside the line.
  a_pixel_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_PIXEL) |-> (out_data.column < eff_w))
    else $error("pixel write past the line width");

  // The image can only end where a line ends.
  a_image_end_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_end |-> out_data.line_end)
    else $error("image end without line end");

  // Words after the image end carry nothing.
  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_IGNORED) |->
      (out_data.byte_address == 26'd0) && !out_data.line_end && !out_data.image_end)
    else $error("ignored word carries data");

  // A parsed word that cannot move on stays in the first stage.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_load |=> s1_v_r)
    else $error("parsed word lost in the pipeline");
`endif

endmodule

`default_nettype wire
